// ===== rtl/wbm_pkg.sv =====
// Package for the windowed byte memory: request and response payload types,
// the command codes, the preload pattern and the default memory size.
// No dependencies.
package wbm_pkg;

	localparam int unsigned MEM_BYTES_DEFAULT = 65536;
	localparam logic [63:0] PRELOAD_PATTERN = 64'h1122_3344_5566_7788;
	localparam logic [3:0] MAX_ACCESS_SIZE = 4'd8;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_STORE = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [63:0] address;
		logic [3:0]  access_size;
		logic [63:0] write_data;
		logic [7:0]  request_id;
	} req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic [7:0]  response_id;
	} rsp_t;

endpackage

// ===== rtl/windowed_byte_memory.sv =====
// Top level of the windowed byte memory: window check, two-bank byte memory
// and the load response register.
// Depends on wbm_pkg for payload types, command codes and constants.

// The block is a byte-addressed memory of MEM_BYTES bytes seen through a
// window that starts at the global address held in the base register. Each
// request transaction is a load or a store of 1 to 8 bytes, little-endian and
// possibly unaligned; sizes of 9 to 15 count as 8. A store that lies fully
// inside the window writes its bytes and returns nothing, and a store that
// does not fit is dropped. Every load returns exactly one response
// transaction with its id, carrying the bytes zero-extended, or zero when the
// range is not fully inside the window. Requests are taken at one per cycle
// when the response side keeps up; a load's response becomes valid once
// it has passed the subtract stage, the memory read stage and the response
// register. The memory is stored as 8-byte words split over an even and an
// odd bank, so an unaligned access touching two neighboring words needs one
// access to each bank, and the single read port of each bank sets the
// one-per-cycle figure. Bytes 0 to 7 read as 0x1122334455667788 after reset
// until they are written; every other byte must be written before it is
// loaded. The base register may only be written while no transaction is in
// flight.
module windowed_byte_memory #(
	parameter int unsigned MEM_BYTES = wbm_pkg::MEM_BYTES_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write_en,
	input  logic [63:0]   cfg_write_data,
	input  logic          req_valid,
	output logic          req_ready,
	input  wbm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output wbm_pkg::rsp_t rsp
);

	// Offset width carries one spare bit so the word index is never empty.
	localparam int unsigned OFF_W = $clog2(MEM_BYTES) + 1;
	localparam int unsigned WORD_W = OFF_W - 3;
	localparam int unsigned WORDS = (MEM_BYTES + 7) / 8;
	localparam int unsigned BANK_DEPTH = (WORDS + 1) / 2;
	localparam int unsigned BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam logic [OFF_W:0] MEM_LIMIT = (OFF_W + 1)'(MEM_BYTES);

	// Control state.
	logic [63:0] base_q;
	logic        v1_q;
	logic        v2_q;
	logic        rsp_valid_q;
	logic [7:0]  pre_wr_q;

	// Stage 1: request with the raw offset from the base.
	wbm_pkg::cmd_t command_s1;
	logic [64:0]   diff_s1;
	logic [3:0]    size_s1;
	logic [63:0]   wdata_s1;
	logic [7:0]    id_s1;

	// Stage 2: load in flight, memory read data registered.
	logic [2:0]      lane_s2;
	logic [3:0]      size_s2;
	logic            inside_s2;
	logic            weven_s2;
	logic [7:0]      id_s2;
	logic [7:0]      pre_sel_s2;
	logic [7:0][7:0] rd_even_s2;
	logic [7:0][7:0] rd_odd_s2;

	wbm_pkg::rsp_t rsp_q;

	logic [7:0][7:0] mem_even [BANK_DEPTH];
	logic [7:0][7:0] mem_odd  [BANK_DEPTH];

	logic out_free;
	logic s2_adv;
	logic req_fire;
	logic [3:0] size_sat;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign s2_adv = !v2_q || out_free;
	assign req_ready = !v1_q || s2_adv;
	assign req_fire = req_valid && req_ready;
	assign size_sat = (req.access_size > wbm_pkg::MAX_ACCESS_SIZE) ?
		wbm_pkg::MAX_ACCESS_SIZE : req.access_size;

	// Window test and bank addressing for the request in stage 1.
	logic              inside_s1;
	logic [OFF_W:0]    end_sum;
	logic [WORD_W-1:0] word_s1;
	logic [2:0]        lane_s1;
	logic [BANK_AW-1:0] even_idx;
	logic [BANK_AW-1:0] odd_idx;
	logic [15:0]       byte_mask;
	logic [15:0]       span_mask;
	logic [127:0]      span_data;
	logic [7:0]        be_even;
	logic [7:0]        be_odd;
	logic [63:0]       wd_even;
	logic [63:0]       wd_odd;
	logic              do_read;
	logic              do_write;
	logic [7:0]        we_even;
	logic [7:0]        we_odd;

	always_comb begin
		end_sum = {1'b0, diff_s1[OFF_W-1:0]} + (OFF_W + 1)'(size_s1);
		// Borrow set means the address lies below the base.
		inside_s1 = !diff_s1[64] && (diff_s1[63:OFF_W] == '0) && (end_sum <= MEM_LIMIT);
		word_s1 = diff_s1[OFF_W-1:3];
		lane_s1 = diff_s1[2:0];
		// Word w and w+1 always fall in different banks.
		odd_idx = BANK_AW'(word_s1 >> 1);
		even_idx = BANK_AW'(({1'b0, word_s1} + (WORD_W + 1)'(1)) >> 1);
		byte_mask = (16'd1 << size_s1) - 16'd1;
		span_mask = byte_mask << lane_s1;
		span_data = {64'd0, wdata_s1} << {lane_s1, 3'b000};
		if (!word_s1[0]) begin
			be_even = span_mask[7:0];
			be_odd = span_mask[15:8];
			wd_even = span_data[63:0];
			wd_odd = span_data[127:64];
		end else begin
			be_even = span_mask[15:8];
			be_odd = span_mask[7:0];
			wd_even = span_data[127:64];
			wd_odd = span_data[63:0];
		end
		do_read = v1_q && s2_adv && (command_s1 == wbm_pkg::CMD_LOAD);
		do_write = v1_q && s2_adv && (command_s1 == wbm_pkg::CMD_STORE) && inside_s1;
		we_even = do_write ? be_even : 8'h00;
		we_odd = do_write ? be_odd : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			pre_wr_q <= '0;
		end else begin
			if (cfg_write_en) begin
				base_q <= cfg_write_data;
			end
			if (req_ready) begin
				v1_q <= req_valid;
			end
			if (s2_adv) begin
				v2_q <= do_read;
			end
			if (out_free) begin
				rsp_valid_q <= v2_q;
			end
			// Once a preload byte is overwritten, the memory holds the truth.
			if (even_idx == '0) begin
				pre_wr_q <= pre_wr_q | we_even;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			command_s1 <= req.command;
			diff_s1 <= {1'b0, req.address} - {1'b0, base_q};
			size_s1 <= size_sat;
			wdata_s1 <= req.write_data;
			id_s1 <= req.request_id;
		end
		if (do_read) begin
			lane_s2 <= lane_s1;
			size_s2 <= size_s1;
			inside_s2 <= inside_s1;
			weven_s2 <= !word_s1[0];
			id_s2 <= id_s1;
			pre_sel_s2 <= (even_idx == '0) ? ~pre_wr_q : 8'h00;
		end
	end

	// Even and odd banks, byte-lane write enables, registered read.
	always_ff @(posedge clk) begin
		for (int j = 0; j < 8; j++) begin
			if (we_even[j]) begin
				mem_even[even_idx][j] <= wd_even[8*j +: 8];
			end
			if (we_odd[j]) begin
				mem_odd[odd_idx][j] <= wd_odd[8*j +: 8];
			end
		end
		if (do_read) begin
			rd_even_s2 <= mem_even[even_idx];
			rd_odd_s2 <= mem_odd[odd_idx];
		end
	end

	// Response assembly: merge preload bytes, align, mask to size.
	logic [63:0]  ev_word;
	logic [127:0] pair;
	logic [127:0] aligned;
	logic [7:0]   keep;
	logic [63:0]  keep64;
	logic [63:0]  load_data;

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			ev_word[8*j +: 8] = pre_sel_s2[j] ? wbm_pkg::PRELOAD_PATTERN[8*j +: 8] :
				rd_even_s2[j];
		end
		pair = weven_s2 ? {rd_odd_s2, ev_word} : {ev_word, rd_odd_s2};
		aligned = pair >> {lane_s2, 3'b000};
		keep = 8'((9'd1 << size_s2) - 9'd1);
		for (int j = 0; j < 8; j++) begin
			keep64[8*j +: 8] = {8{keep[j]}};
		end
		load_data = inside_s2 ? (aligned[63:0] & keep64) : 64'd0;
	end

	always_ff @(posedge clk) begin
		if (out_free && v2_q) begin
			rsp_q.read_data <= load_data;
			rsp_q.response_id <= id_s2;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// A store never reaches the response side.
	a_store_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && s2_adv && command_s1 == wbm_pkg::CMD_STORE) |=> !v2_q)
		else $error("store entered the load pipeline");

	// A write moves exactly as many bytes as the request size.
	a_write_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |-> ($countones({we_odd, we_even}) == int'(size_s1)))
		else $error("byte enable count differs from access size");

	// The preload overwrite marks only ever accumulate.
	a_pre_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		((pre_wr_q & $past(pre_wr_q)) == $past(pre_wr_q)))
		else $error("preload overwrite mark cleared");

	// A response only appears from a load that was in the read stage.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(v2_q))
		else $error("response without a load in flight");

	// A load in flight is never lost while the response register is blocked.
	a_load_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && rsp_valid_q && !rsp_ready) |=> (v2_q && rsp_valid_q))
		else $error("stalled load dropped");

endmodule

// ===== bench/wbm_mirror_pkg.sv =====
// Scoreboard for the windowed byte memory bench: a byte-level mirror of the
// memory and the queue of load responses still owed by the block.
// Depends on wbm_pkg for the payload types, command codes and constants.
package wbm_mirror_pkg;

	import wbm_pkg::*;

	class memory_mirror;
		localparam int unsigned WINDOW_BYTES = MEM_BYTES_DEFAULT;

		logic [7:0]  image [WINDOW_BYTES];
		bit          written [WINDOW_BYTES];
		logic [63:0] base;
		rsp_t        awaited_loads [$];
		int unsigned mismatches;

		function new();
			base = '0;
			mismatches = 0;
			for (int i = 0; i < WINDOW_BYTES; i++) begin
				image[i] = 8'h00;
				written[i] = 1'b0;
			end
			// The preloaded pattern counts as written data.
			for (int i = 0; i < 8; i++) begin
				image[i] = PRELOAD_PATTERN[8*i +: 8];
				written[i] = 1'b1;
			end
		endfunction

		function void set_base(input logic [63:0] value);
			base = value;
		endfunction

		function int unsigned outstanding();
			return awaited_loads.size();
		endfunction

		// Sizes of 9 to 15 move eight bytes.
		function int unsigned bytes_moved(input logic [3:0] size);
			return (size > MAX_ACCESS_SIZE) ? int'(MAX_ACCESS_SIZE) : int'(size);
		endfunction

		// Addresses below the base never wrap around into the window.
		function bit in_window(input logic [63:0] address, input logic [3:0] size,
				output logic [63:0] offset);
			offset = address - base;
			return (address >= base) &&
				(offset <= 64'(WINDOW_BYTES) - 64'(bytes_moved(size)));
		endfunction

		// A load may only touch bytes that hold defined data.
		function bit load_is_safe(input logic [63:0] address, input logic [3:0] size);
			logic [63:0] offset;
			if (!in_window(address, size, offset))
				return 1'b1;
			for (int i = 0; i < bytes_moved(size); i++)
				if (!written[int'(offset) + i])
					return 1'b0;
			return 1'b1;
		endfunction

		function void note_request(input req_t r);
			logic [63:0] offset;
			bit          fits;
			rsp_t        owed;
			fits = in_window(r.address, r.access_size, offset);
			if (r.command == CMD_STORE) begin
				if (fits) begin
					for (int i = 0; i < bytes_moved(r.access_size); i++) begin
						image[int'(offset) + i] = r.write_data[8*i +: 8];
						written[int'(offset) + i] = 1'b1;
					end
				end
				return;
			end
			owed.read_data = '0;
			owed.response_id = r.request_id;
			if (fits)
				for (int i = 0; i < bytes_moved(r.access_size); i++)
					owed.read_data[8*i +: 8] = image[int'(offset) + i];
			awaited_loads.push_back(owed);
		endfunction

		function void check_response(input rsp_t r);
			rsp_t owed;
			if (awaited_loads.size() == 0) begin
				$error("response id %0d arrived with no load outstanding", r.response_id);
				mismatches++;
				return;
			end
			owed = awaited_loads.pop_front();
			if (r.read_data !== owed.read_data) begin
				$error("read_data: expected %h, got %h", owed.read_data, r.read_data);
				mismatches++;
			end
			if (r.response_id !== owed.response_id) begin
				$error("response_id: expected %0d, got %0d", owed.response_id,
					r.response_id);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// ===== bench/testbench.sv =====
// Top-level bench for windowed_byte_memory: drives request and response
// channels with random pacing and checks every load response in order.
// Depends on wbm_pkg, wbm_mirror_pkg and the windowed_byte_memory RTL.
module testbench;

	import wbm_pkg::*;
	import wbm_mirror_pkg::*;

	localparam int unsigned WINDOW_BYTES = MEM_BYTES_DEFAULT;
	// The response side stops for this long once, after HOLD_AFTER responses,
	// so the pipeline fills and the request side must stall.
	localparam int unsigned HOLD_AFTER = 150;
	localparam int unsigned LONG_HOLD = 400;

	logic        clk;
	logic        arst_n;
	logic        cfg_write_en;
	logic [63:0] cfg_write_data;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;

	memory_mirror mirror;
	int unsigned  responses_seen;
	bit           long_hold_done;
	int unsigned  burst_left;

	windowed_byte_memory i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp            (rsp)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int unsigned idle_cycles();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_t make_request(input cmd_t command, input logic [63:0] address,
			input logic [3:0] size, input logic [63:0] data, input logic [7:0] id);
		req_t r;
		r.command = command;
		r.address = address;
		r.access_size = size;
		r.write_data = data;
		r.request_id = id;
		return r;
	endfunction

	// Most requests land in two small hot regions, one at each end of the
	// window, so stores fill them quickly and later loads read back real data.
	// The rest probe the window edges, addresses just below the base and
	// fully random addresses. A load that would touch a byte never written
	// is turned into a store to the same place, which also fills the region.
	function automatic req_t random_request();
		req_t        r;
		int unsigned kind;
		int unsigned size_pick;
		int unsigned moved;
		int unsigned offset;
		kind = $urandom_range(0, 99);
		size_pick = $urandom_range(0, 99);
		r.command = ($urandom_range(0, 1) == 1) ? CMD_STORE : CMD_LOAD;
		if (size_pick < 85)
			r.access_size = 4'($urandom_range(1, 8));
		else if (size_pick < 92)
			r.access_size = 4'd0;
		else
			r.access_size = 4'($urandom_range(9, 15));
		r.write_data = {$urandom, $urandom};
		r.request_id = 8'($urandom_range(0, 255));
		moved = mirror.bytes_moved(r.access_size);
		if (kind < 80) begin
			if ($urandom_range(0, 99) < 70)
				offset = $urandom_range(0, 255);
			else
				offset = WINDOW_BYTES - 264 + $urandom_range(0, 263);
			r.address = mirror.base + 64'(offset);
		end else if (kind < 90) begin
			// Straddle the top of the window by up to two bytes either way.
			offset = WINDOW_BYTES - moved + $urandom_range(0, 4) - 2;
			r.address = mirror.base + 64'(offset);
		end else if (kind < 95) begin
			r.address = mirror.base - 64'($urandom_range(1, 16));
		end else begin
			r.address = {$urandom, $urandom};
		end
		if (r.command == CMD_LOAD && !mirror.load_is_safe(r.address, r.access_size))
			r.command = CMD_STORE;
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the
	// transaction is accepted, with valid still high. The caller either
	// offers the next request there or lowers valid.
	task automatic send_request(input req_t r);
		int unsigned gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = idle_cycles();
			if ($urandom_range(0, 99) < 5)
				burst_left = $urandom_range(16, 48);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (!req_ready);
		mirror.note_request(r);
		@(negedge clk);
	endtask

	task automatic run_random(input int unsigned count);
		repeat (count)
			send_request(random_request());
	endtask

	// The base register is only written with nothing in flight. Stores give
	// no response, so the task keeps waiting after the last load is answered
	// to let the last of them retire.
	task automatic write_base(input logic [63:0] value);
		req_valid <= 1'b0;
		while (mirror.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		mirror.set_base(value);
	endtask

	// Directed opening with the base at its reset value of zero: the preload
	// pattern, unaligned reads, a zero-size access, oversize sizes that act
	// as eight bytes, a store across a word boundary, the last bytes of the
	// window, accesses one byte past it, and id and data extremes.
	task automatic run_directed();
		logic [63:0] top;
		top = 64'(WINDOW_BYTES);
		send_request(make_request(CMD_LOAD, 64'd0, 4'd8, 64'd0, 8'd0));
		send_request(make_request(CMD_LOAD, 64'd3, 4'd4, 64'd0, 8'd255));
		send_request(make_request(CMD_LOAD, 64'd0, 4'd0, 64'd0, 8'd1));
		send_request(make_request(CMD_LOAD, 64'd0, 4'd12, 64'd0, 8'd2));
		send_request(make_request(CMD_STORE, 64'd5, 4'd8, '1, 8'd3));
		send_request(make_request(CMD_LOAD, 64'd5, 4'd8, 64'd0, 8'd4));
		send_request(make_request(CMD_LOAD, 64'd1, 4'd8, 64'd0, 8'd5));
		send_request(make_request(CMD_STORE, 64'd0, 4'd0, '1, 8'd6));
		send_request(make_request(CMD_LOAD, 64'd0, 4'd8, 64'd0, 8'd7));
		send_request(make_request(CMD_STORE, 64'd16, 4'd15, 64'h0123_4567_89ab_cdef, 8'd8));
		send_request(make_request(CMD_LOAD, 64'd17, 4'd7, 64'd0, 8'd9));
		send_request(make_request(CMD_STORE, top - 64'd8, 4'd8, 64'ha5c3_0ff0_5a3c_e11e,
			8'd10));
		send_request(make_request(CMD_LOAD, top - 64'd8, 4'd8, 64'd0, 8'd11));
		send_request(make_request(CMD_LOAD, top - 64'd7, 4'd8, 64'd0, 8'd12));
		send_request(make_request(CMD_STORE, top - 64'd7, 4'd8, '1, 8'd13));
		send_request(make_request(CMD_LOAD, top - 64'd1, 4'd1, 64'd0, 8'd14));
		send_request(make_request(CMD_LOAD, '1, 4'd1, 64'd0, 8'd15));
		send_request(make_request(CMD_STORE, '1, 4'd8, '1, 8'd16));
		send_request(make_request(CMD_LOAD, 64'd0, 4'd15, 64'd0, 8'd255));
		send_request(make_request(CMD_STORE, 64'd24, 4'd1, 64'd0, 8'd0));
		send_request(make_request(CMD_LOAD, 64'd24, 4'd1, 64'd0, 8'd17));
	endtask

	// Request side and overall sequence. Reset is applied once, then the
	// directed part runs, then random traffic under several base settings,
	// including both extremes and a window that ends at the top of the
	// address space.
	initial begin : request_side
		mirror = new();
		burst_left = 0;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		req_valid = 1'b0;
		req = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		run_directed();
		write_base(64'hFFFF_FFFF_FFFF_0000);
		run_random(260);
		write_base('1);
		run_random(120);
		write_base({$urandom, $urandom});
		run_random(260);
		write_base(64'h8000_0000_0000_0000);
		run_random(200);
		write_base(64'd0);
		run_random(360);
		req_valid <= 1'b0;
		// Let the last loads drain, then give a stray response time to show.
		while (mirror.outstanding() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mirror.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Response side: runs of ready broken by random stalls, plus one long
	// hold-off that backs the block up into the request channel.
	initial begin : response_side
		int unsigned run_len;
		int unsigned stall_len;
		responses_seen = 0;
		long_hold_done = 1'b0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!long_hold_done && responses_seen >= HOLD_AFTER) begin
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_done = 1'b1;
			end
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 100) :
				$urandom_range(1, 40);
			rsp_ready <= 1'b1;
			repeat (run_len) @(negedge clk);
			stall_len = idle_cycles();
			if (stall_len > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall_len) @(negedge clk);
			end
		end
	end

	// Every accepted response transaction is checked against the oldest
	// load still owed.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			mirror.check_response(rsp);
			responses_seen <= responses_seen + 1;
		end
	end

	// Safety net: a hung handshake ends the run as a failure.
	initial begin : run_limit
		#8000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
